FILE: sv/deque_with_remove_by_value_assert.svh
`ifndef DEQUE_WITH_REMOVE_BY_VALUE_ASSERT_SVH
`define DEQUE_WITH_REMOVE_BY_VALUE_ASSERT_SVH

// Concurrent checks on clk; DWR_CHECK is silent during reset, DWR_CHECK_ALWAYS is not.
`ifndef NO_ASSERTIONS
`define DWR_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DWR_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DWR_CHECK(label, prop, msg)
`define DWR_CHECK_ALWAYS(label, prop, msg)
`endif

`endif

FILE: sv/dwr_pkg.sv
package dwr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;

  localparam logic [KIND_W-1:0] K_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] K_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] K_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] K_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] K_REMOVE     = 3'd4;
  localparam logic [KIND_W-1:0] K_DUMP       = 3'd5;

  localparam logic [STATUS_W-1:0] S_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] S_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] S_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] S_FULL     = 2'd3;

  typedef logic [2:0] op_t;

  // cell commands
  localparam op_t OP_HOLD  = 3'd0;
  localparam op_t OP_PUT   = 3'd1;  // cell at pos takes operand
  localparam op_t OP_RIGHT = 3'd2;  // every cell takes its front neighbor, cell 0 the operand
  localparam op_t OP_LEFT  = 3'd3;  // every cell takes its back neighbor, the last cell the head
  localparam op_t OP_ROT   = 3'd4;  // like LEFT, cell at pos takes the head

endpackage

FILE: sv/dwr_cell.sv
module dwr_cell #(
  parameter int POS_W = 4,
  parameter int IDX   = 0
) (
  input  logic                        clk,
  input  dwr_pkg::op_t                op,
  input  logic [POS_W-1:0]            pos,
  input  logic [dwr_pkg::DATA_W-1:0]  operand,
  input  logic [dwr_pkg::DATA_W-1:0]  prev,
  input  logic [dwr_pkg::DATA_W-1:0]  next,
  input  logic [dwr_pkg::DATA_W-1:0]  head,
  output logic [dwr_pkg::DATA_W-1:0]  q
);
  import dwr_pkg::*;

  logic              hit;
  logic [DATA_W-1:0] q_next;

  assign hit = (pos == POS_W'(IDX));

  always_comb begin
    case (op)
      OP_HOLD:  q_next = q;
      OP_PUT:   q_next = hit ? operand : q;
      OP_RIGHT: q_next = prev;
      OP_LEFT:  q_next = next;
      OP_ROT:   q_next = hit ? head : next;
      default:  q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: sv/deque_with_remove_by_value.sv
// Bounded deque of 32-bit words kept in a row of DEPTH cells, front in cell 0.
// Push front, push back and pop front finish in the cycle the item is taken.
// Pop back and remove by value walk the row by rotating it once, one entry a
// cycle while the output register is free, and give a single result at the end.
// Dump also rotates the row, sends one item per stored entry, one a cycle while
// the output register is free, from the cycle after the item is taken. Every
// item but an undefined kind yields at least one result; the input is taken again
// once the block is idle and the output register is empty or being read.
`include "deque_with_remove_by_value_assert.svh"

module deque_with_remove_by_value #(
  parameter int DEPTH = dwr_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dwr_pkg::DATA_W-1:0]    s_tdata,   // operand
  input  logic [dwr_pkg::KIND_W-1:0]    s_tuser,   // kind
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dwr_pkg::DATA_W-1:0]    m_tdata,   // item_value
  output logic [dwr_pkg::STATUS_W-1:0]  m_tuser,   // status
  output logic                          m_tlast    // last_of_run
);
  import dwr_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  logic [1:0]          state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    rem, rem_next;
  logic                found, found_next;
  logic                back, back_next;
  logic [DATA_W-1:0]   key, key_next;
  logic [DATA_W-1:0]   hold, hold_next;

  logic [DATA_W-1:0]   cell_q [DEPTH];
  logic [DATA_W-1:0]   head;
  op_t                 op;
  logic [POS_W-1:0]    pos;
  logic [CNT_W-1:0]    cnt_m1;

  logic                out_free;
  logic                accept;
  logic                drop;
  logic                emit;
  logic [DATA_W-1:0]   e_val;
  logic [STATUS_W-1:0] e_st;
  logic                e_last;
  logic                push_ok;

  assign head     = cell_q[0];
  assign cnt_m1   = count - 1'b1;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign drop     = !found && (back ? (rem == CNT_W'(1)) : (head == key));

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      dwr_cell #(.POS_W(POS_W), .IDX(gi)) u_cell (
        .clk     (clk),
        .op      (op),
        .pos     (pos),
        .operand (s_tdata),
        .prev    ((gi == 0) ? s_tdata : cell_q[(gi == 0) ? 0 : gi - 1]),
        .next    ((gi == DEPTH - 1) ? head : cell_q[(gi == DEPTH - 1) ? gi : gi + 1]),
        .head    (head),
        .q       (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    op         = OP_HOLD;
    pos        = '0;
    state_next = state;
    count_next = count;
    rem_next   = rem;
    found_next = found;
    back_next  = back;
    key_next   = key;
    hold_next  = hold;
    emit       = 1'b0;
    e_val      = '0;
    e_st       = S_OK;
    e_last     = 1'b1;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (s_tuser)
            K_PUSH_FRONT, K_PUSH_BACK: begin
              emit = 1'b1;
              if (count == CNT_FULL) begin
                e_st = S_FULL;
              end else begin
                op         = (s_tuser == K_PUSH_FRONT) ? OP_RIGHT : OP_PUT;
                pos        = count[POS_W-1:0];
                count_next = count + 1'b1;
              end
            end
            K_POP_FRONT: begin
              emit = 1'b1;
              if (count == '0) begin
                e_st = S_EMPTY;
              end else begin
                e_val      = head;
                op         = OP_LEFT;
                count_next = cnt_m1;
              end
            end
            K_POP_BACK, K_REMOVE: begin
              if (count == '0) begin
                emit = 1'b1;
                e_st = S_EMPTY;
              end else begin
                state_next = ST_WALK;
                rem_next   = count;
                found_next = 1'b0;
                key_next   = s_tdata;
                back_next  = (s_tuser == K_POP_BACK);
              end
            end
            K_DUMP: begin
              if (count == '0) begin
                emit = 1'b1;
                e_st = S_EMPTY;
              end else begin
                state_next = ST_DUMP;
                rem_next   = count;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (out_free) begin
          if (drop) begin
            op         = OP_LEFT;
            count_next = cnt_m1;
            found_next = 1'b1;
            hold_next  = head;
          end else begin
            op  = OP_ROT;
            pos = cnt_m1[POS_W-1:0];
          end
          rem_next = rem - 1'b1;
          if (rem == CNT_W'(1)) begin
            emit       = 1'b1;
            e_val      = drop ? head : (found ? hold : '0);
            e_st       = (drop || found) ? S_OK : S_NOTFOUND;
            state_next = ST_IDLE;
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          op       = OP_ROT;
          pos      = cnt_m1[POS_W-1:0];
          emit     = 1'b1;
          e_val    = head;
          e_last   = (rem == CNT_W'(1));
          rem_next = rem - 1'b1;
          if (rem == CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rem      <= '0;
      found    <= 1'b0;
      back     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rem   <= rem_next;
      found <= found_next;
      back  <= back_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key  <= key_next;
    hold <= hold_next;
    if (emit) begin
      m_tdata <= e_val;
      m_tuser <= e_st;
      m_tlast <= e_last;
    end
  end

  assign push_ok = accept && (s_tuser == K_PUSH_FRONT || s_tuser == K_PUSH_BACK) &&
                   (count != CNT_FULL);

  `DWR_CHECK(a_count_bound, count <= CNT_FULL, "occupancy above depth")
  `DWR_CHECK(a_busy_no_accept, (state != ST_IDLE) |-> !s_tready, "item taken while busy")
  `DWR_CHECK(a_push_grows, push_ok |=> (count == $past(count) + 1'b1), "push lost")
  `DWR_CHECK(a_walk_bound, (state != ST_IDLE) |-> (rem != '0 && rem <= count), "walk count")

endmodule

FILE: tb/tb_deque_with_remove_by_value.sv
`timescale 1ns / 100ps

module tb_deque_with_remove_by_value;
  import dwr_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int LIMIT = 200000;
  localparam int RANDOM_ITEMS = 128;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 40;

  // kinds the block drops without a result
  localparam logic [KIND_W-1:0] K_UNDEF_A = 3'd6;
  localparam logic [KIND_W-1:0] K_UNDEF_B = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
    logic                last;
  } deque_result_t;

  class deque_scoreboard;
    logic [DATA_W-1:0] entries[$];
    deque_result_t     pending[$];
    int depth_limit;
    int errors;
    int items;
    int results;
    int peak;
    int full_hits;
    int miss_hits;

    function new(int depth_limit_i);
      depth_limit = depth_limit_i;
    endfunction

    function void add(logic [DATA_W-1:0] value, logic [STATUS_W-1:0] status, logic last);
      deque_result_t r;
      r.value = value;
      r.status = status;
      r.last = last;
      pending.push_back(r);
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] operand);
      logic [DATA_W-1:0] v;
      int hit;
      hit = -1;
      items++;
      case (kind)
        K_PUSH_FRONT, K_PUSH_BACK: begin
          if (entries.size() >= depth_limit) begin
            full_hits++;
            add('0, S_FULL, 1'b1);
          end else begin
            if (kind == K_PUSH_FRONT) entries.push_front(operand);
            else entries.push_back(operand);
            add('0, S_OK, 1'b1);
          end
        end
        K_POP_FRONT, K_POP_BACK: begin
          if (entries.size() == 0) begin
            add('0, S_EMPTY, 1'b1);
          end else begin
            if (kind == K_POP_FRONT) v = entries.pop_front();
            else v = entries.pop_back();
            add(v, S_OK, 1'b1);
          end
        end
        K_REMOVE: begin
          if (entries.size() == 0) begin
            add('0, S_EMPTY, 1'b1);
          end else begin
            foreach (entries[i])
              if (hit < 0 && entries[i] == operand) hit = i;
            if (hit < 0) begin
              miss_hits++;
              add('0, S_NOTFOUND, 1'b1);
            end else begin
              add(entries[hit], S_OK, 1'b1);
              entries.delete(hit);
            end
          end
        end
        K_DUMP: begin
          if (entries.size() == 0) begin
            add('0, S_EMPTY, 1'b1);
          end else begin
            foreach (entries[i])
              add(entries[i], S_OK, i == entries.size() - 1);
          end
        end
        default: items--;
      endcase
      if (entries.size() > peak) peak = entries.size();
    endfunction

    function void check_result(logic [DATA_W-1:0] value, logic [STATUS_W-1:0] status,
                               logic last);
      deque_result_t e;
      results++;
      if (pending.size() == 0) begin
        errors++;
        $error("unexpected result: item_value %h status %0d last_of_run %b",
               value, status, last);
      end else begin
        e = pending.pop_front();
        if (e.value !== value) begin
          errors++;
          $error("item_value expected %h got %h", e.value, value);
        end
        if (e.status !== status) begin
          errors++;
          $error("status expected %0d got %0d", e.status, status);
        end
        if (e.last !== last) begin
          errors++;
          $error("last_of_run expected %b got %b", e.last, last);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata = '0;
  logic [KIND_W-1:0]   s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic                m_tlast;

  bit quiet;
  bit hold_now;
  int cycles;
  deque_scoreboard sb;

  deque_with_remove_by_value #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
      if (hold_now) begin
        hold_left = HOLD_CYCLES;
        hold_now = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] operand);
    while (!quiet && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= operand;
    do @(posedge clk); while (!s_tready);
    sb.note_item(kind, operand);
  endtask

  // stop offering until every outstanding result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin : stimulus
    int n;
    int r;
    int push_pct;
    logic [KIND_W-1:0] k;
    logic [DATA_W-1:0] w;
    sb = new(DEPTH);
    quiet = 1'b0;
    hold_now = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty deque
    send_item(K_DUMP, '0);
    send_item(K_POP_FRONT, '0);
    send_item(K_POP_BACK, '0);
    send_item(K_REMOVE, 32'h0000_1234);
    // extremes, duplicate value
    send_item(K_PUSH_FRONT, 32'h8000_0000);
    send_item(K_PUSH_BACK, 32'h7fff_ffff);
    send_item(K_PUSH_FRONT, 32'hffff_ffff);
    send_item(K_PUSH_BACK, 32'h0000_0000);
    send_item(K_PUSH_BACK, 32'h7fff_ffff);
    send_item(K_DUMP, '0);
    send_item(K_REMOVE, 32'h0000_1234);
    send_item(K_REMOVE, 32'h7fff_ffff);
    send_item(K_UNDEF_A, 32'h7fff_ffff);
    send_item(K_UNDEF_B, 32'hffff_ffff);
    send_item(K_POP_FRONT, '0);
    send_item(K_POP_BACK, '0);
    send_item(K_DUMP, '0);
    send_item(K_REMOVE, 32'h8000_0000);
    send_item(K_REMOVE, 32'h0000_0000);
    send_item(K_DUMP, '0);
    settle();

    // overfill while the sink is held off
    hold_now = 1'b1;
    for (n = 0; n < DEPTH + 4; n++)
      send_item((n % 2) ? K_PUSH_BACK : K_PUSH_FRONT, $urandom());
    settle();
    send_item(K_DUMP, '0);
    send_item(K_PUSH_BACK, 32'h5555_aaaa);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 60 && n < 100);
      r = $urandom_range(99);
      push_pct = ((n / 30) % 2 == 0) ? 48 : 24;
      if (r >= 96) k = (r % 2) ? K_UNDEF_B : K_UNDEF_A;
      else if (r >= 88) k = K_DUMP;
      else if (r >= 72) k = K_REMOVE;
      else if (r < push_pct) k = (r % 2) ? K_PUSH_BACK : K_PUSH_FRONT;
      else k = (r % 2) ? K_POP_BACK : K_POP_FRONT;
      case ($urandom_range(9))
        0: w = 32'h8000_0000;
        1: w = 32'h7fff_ffff;
        2: w = 32'hffff_ffff;
        3: w = 32'h0000_0000;
        4, 5, 6: w = $urandom_range(7);
        default: w = $urandom();
      endcase
      if (k == K_REMOVE && sb.entries.size() != 0 && $urandom_range(2) != 0)
        w = sb.entries[$urandom_range(sb.entries.size() - 1)];
      send_item(k, w);
      if (n == 120) settle();
    end

    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items and %0d results, peak fill %0d of %0d", sb.items,
             sb.results, sb.peak, DEPTH);
    $display("pushes refused as full: %0d, removes with no match: %0d", sb.full_hits,
             sb.miss_hits);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/dwr_pkg.sv
sv/dwr_cell.sv
sv/deque_with_remove_by_value.sv
tb/tb_deque_with_remove_by_value.sv
